### src/postfix_expression_evaluator_assert.svh
// assertion macros used by the checker file
// depends on nothing
`ifndef POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
// implication checked at every rising clock edge outside reset
`define PEE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication checked outside reset
`define PEE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

### src/pee_pkg.sv
// shared types and constants of the postfix expression evaluator
// depends on nothing
package pee_pkg;
   localparam int STACK_DEPTH = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int SP_WIDTH    = $clog2(STACK_DEPTH);
   localparam int CNT_WIDTH   = $clog2(STACK_DEPTH + 1);
   localparam int DIV_CNT_W   = $clog2(VALUE_WIDTH + 1);

   typedef logic [VALUE_WIDTH-1:0] value_type;
   typedef logic [CNT_WIDTH-1:0]   count_type;
   typedef logic [7:0]             char_type;

   localparam char_type CH_PLUS  = 8'h2b;
   localparam char_type CH_MINUS = 8'h2d;
   localparam char_type CH_STAR  = 8'h2a;
   localparam char_type CH_SLASH = 8'h2f;
   localparam char_type CH_CARET = 8'h5e;
   localparam char_type CH_ZERO  = 8'h30;
   localparam char_type CH_NINE  = 8'h39;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_FEW      = 3'd1,
      ST_DIV_ZERO = 3'd2,
      ST_OVERFLOW = 3'd3,
      ST_EMPTY    = 3'd4,
      ST_ZERO_POW = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_POW
   } op_type;

   // controller to datapath commands
   typedef struct packed {
      logic     load_char;   // latch incoming character
      logic     digit;       // fold digit into accumulator
      logic     finish_num;  // push accumulated number
      logic     fetch;       // read two operands from the stack
      logic     alu_start;   // start operation on fetched operands
      logic     alu_push;    // push alu result
      logic     op_minus;    // use subtraction instead of latched op
      logic     set_pending; // remember a minus sign
      logic     set_few;     // flag too few operands
      logic     set_empty;   // flag empty stack at end
      logic     clear_all;   // return to reset state
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic is_digit;
      logic is_minus;
      logic is_op;
      logic in_number;
      logic pending_minus;
      logic two_operands;
      logic stack_empty;
      logic alu_done;
   } stat_type;

   function automatic status_type first_err(status_type cur, status_type nxt);
      first_err = (cur == ST_OK) ? nxt : cur;
   endfunction
endpackage

### src/pee_if.sv
// valid/ready channel interface for request beats
// depends on pee_pkg
interface pee_req_if;
   logic              valid;
   logic              ready;
   pee_pkg::char_type char_code;
   logic              last_char;
   modport source (output valid, char_code, last_char, input ready);
   modport sink   (input valid, char_code, last_char, output ready);
endinterface

### src/pee_rsp_if.sv
// response channel interface
// depends on pee_pkg
interface pee_rsp_if;
   logic                valid;
   logic                ready;
   pee_pkg::value_type  value;
   logic [2:0]          status;
   modport source (output valid, value, status, input ready);
   modport sink   (input valid, value, status, output ready);
endinterface

### src/pee_alu.sv
// iterative arithmetic unit: add, subtract, multiply, divide, power
// depends on pee_pkg
module pee_alu (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  pee_pkg::op_type    op,
   input  pee_pkg::value_type a,
   input  pee_pkg::value_type b,
   output logic               done,
   output pee_pkg::value_type result,
   output logic               div_zero,
   output logic               zero_pow
);
   import pee_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_POW_M, S_POW_S, S_FIX} state_type;

   state_type            state_ff, state_in;
   value_type            acc_ff, acc_in;      // result / remainder
   value_type            quo_ff, quo_in;      // quotient, multiplicand or power base
   value_type            opb_ff, opb_in;      // divisor magnitude, multiplier or exponent
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 neg_ff, neg_in;
   logic                 done_ff, done_in;
   logic                 dz_ff, dz_in, zp_ff, zp_in;
   value_type            prod_ff, prod_in;

   value_type ma, mb, rem_sh;
   logic      sa, sb;
   logic [VALUE_WIDTH:0] trial;

   assign sa = a[VALUE_WIDTH-1];
   assign sb = b[VALUE_WIDTH-1];
   assign ma = sa ? (~a + 1'b1) : a;
   assign mb = sb ? (~b + 1'b1) : b;
   assign rem_sh = {acc_ff[VALUE_WIDTH-2:0], quo_ff[VALUE_WIDTH-1]};
   assign trial  = {1'b0, rem_sh} - {1'b0, opb_ff};

   // sequencing of multi-cycle operations
   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      quo_in   = quo_ff;
      opb_in   = opb_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      done_in  = 1'b0;
      dz_in    = dz_ff;
      zp_in    = zp_ff;
      prod_in  = prod_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               dz_in = 1'b0;
               zp_in = 1'b0;
               unique case (op)
                  OP_ADD: begin acc_in = a + b; done_in = 1'b1; end
                  OP_SUB: begin acc_in = a - b; done_in = 1'b1; end
                  OP_MUL: begin quo_in = a; opb_in = b; state_in = S_MUL; end
                  OP_DIV: begin
                     if (b == '0) begin
                        acc_in = '0; dz_in = 1'b1; done_in = 1'b1;
                     end else begin
                        acc_in   = '0;
                        quo_in   = ma;
                        opb_in   = mb;
                        neg_in   = sa ^ sb;
                        cnt_in   = DIV_CNT_W'(VALUE_WIDTH);
                        state_in = S_DIV;
                     end
                  end
                  OP_POW: begin
                     if (sb) begin
                        done_in = 1'b1;
                        if (a == value_type'(1)) acc_in = value_type'(1);
                        else if (a == '1) acc_in = b[0] ? '1 : value_type'(1);
                        else begin acc_in = '0; zp_in = (a == '0); end
                     end else begin
                        acc_in   = value_type'(1);
                        quo_in   = a;
                        opb_in   = b;
                        state_in = S_POW_M;
                     end
                  end
                  default: begin acc_in = '0; done_in = 1'b1; end
               endcase
            end
         end
         S_MUL: begin
            acc_in   = quo_ff * opb_ff;
            done_in  = 1'b1;
            state_in = S_IDLE;
         end
         S_DIV: begin
            // one restoring step per cycle
            quo_in = {quo_ff[VALUE_WIDTH-2:0], ~trial[VALUE_WIDTH]};
            acc_in = trial[VALUE_WIDTH] ? rem_sh : trial[VALUE_WIDTH-1:0];
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_W'(1)) state_in = S_FIX;
         end
         S_FIX: begin
            acc_in   = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
            done_in  = 1'b1;
            state_in = S_IDLE;
         end
         S_POW_M: begin
            // multiply step: result times base when exponent bit set
            if (opb_ff == '0) begin
               done_in  = 1'b1;
               state_in = S_IDLE;
            end else begin
               prod_in  = acc_ff * quo_ff;
               state_in = S_POW_S;
            end
         end
         S_POW_S: begin
            if (opb_ff[0]) acc_in = prod_ff;
            quo_in   = quo_ff * quo_ff;
            opb_in   = opb_ff >> 1;
            state_in = S_POW_M;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      acc_ff  <= acc_in;
      quo_ff  <= quo_in;
      opb_ff  <= opb_in;
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      dz_ff   <= dz_in;
      zp_ff   <= zp_in;
      prod_ff <= prod_in;
   end

   assign done     = done_ff;
   assign result   = acc_ff;
   assign div_zero = dz_ff;
   assign zero_pow = zp_ff;
endmodule

### src/pee_datapath.sv
// datapath: operand stack, number accumulator, status and alu
// depends on pee_pkg, pee_alu
module pee_datapath (
   input  logic               clock,
   input  logic               reset,
   input  pee_pkg::cmd_type   cmd,
   input  pee_pkg::char_type  char_code,
   output pee_pkg::stat_type  stat,
   output pee_pkg::value_type top_value,
   output logic [2:0]         status
);
   import pee_pkg::*;

   value_type  stack_mem [STACK_DEPTH];
   count_type  count_ff, count_in;
   value_type  num_ff, num_in;
   logic       in_num_ff, in_num_in;
   logic       neg_ff, neg_in;
   logic       pend_ff, pend_in;
   status_type err_ff, err_in;
   char_type   ch_ff;
   op_type     op_ff;
   value_type  opa_ff, opb_ff;

   logic       alu_done, alu_dz, alu_zp;
   value_type  alu_res;
   op_type     alu_op;
   logic       push_en;
   value_type  push_val;
   logic       full;

   logic [VALUE_WIDTH+3:0] num_x10;

   assign full   = (count_ff == count_type'(STACK_DEPTH));
   assign alu_op = cmd.op_minus ? OP_SUB : op_ff;
   assign num_x10 = {1'b0, num_ff, 3'b000} + {3'b000, num_ff, 1'b0}
                    + {{(VALUE_WIDTH){1'b0}}, ch_ff[3:0]};

   pee_alu u_alu (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.alu_start),
      .op       (alu_op),
      .a        (opa_ff),
      .b        (opb_ff),
      .done     (alu_done),
      .result   (alu_res),
      .div_zero (alu_dz),
      .zero_pow (alu_zp)
   );

   // push source and control state update
   always_comb begin
      count_in  = count_ff;
      num_in    = num_ff;
      in_num_in = in_num_ff;
      neg_in    = neg_ff;
      pend_in   = pend_ff;
      err_in    = err_ff;
      push_en   = 1'b0;
      push_val  = alu_res;
      if (cmd.digit) begin
         if (in_num_ff) num_in = num_x10[VALUE_WIDTH-1:0];
         else begin
            in_num_in = 1'b1;
            neg_in    = pend_ff;
            pend_in   = 1'b0;
            num_in    = value_type'(ch_ff[3:0]);
         end
      end
      if (cmd.finish_num) begin
         push_en   = 1'b1;
         push_val  = neg_ff ? (~num_ff + 1'b1) : num_ff;
         in_num_in = 1'b0;
         neg_in    = 1'b0;
         num_in    = '0;
      end
      if (cmd.fetch) begin
         count_in = count_ff - count_type'(2);
         if (cmd.op_minus) pend_in = 1'b0;
      end
      if (cmd.alu_push) begin
         push_en = 1'b1;
         if (alu_dz) err_in = first_err(err_in, ST_DIV_ZERO);
         if (alu_zp) err_in = first_err(err_in, ST_ZERO_POW);
      end
      if (cmd.op_minus && cmd.set_few) pend_in = 1'b0;
      if (cmd.set_few)   err_in = first_err(err_in, ST_FEW);
      if (cmd.set_empty) err_in = first_err(err_in, ST_EMPTY);
      if (cmd.set_pending) pend_in = 1'b1;
      if (push_en) begin
         if (full) err_in = first_err(err_in, ST_OVERFLOW);
         else count_in = count_ff + 1'b1;
      end
      if (cmd.clear_all) begin
         count_in  = '0;
         num_in    = '0;
         in_num_in = 1'b0;
         neg_in    = 1'b0;
         pend_in   = 1'b0;
         err_in    = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         num_ff    <= '0;
         in_num_ff <= 1'b0;
         neg_ff    <= 1'b0;
         pend_ff   <= 1'b0;
         err_ff    <= ST_OK;
      end else begin
         count_ff  <= count_in;
         num_ff    <= num_in;
         in_num_ff <= in_num_in;
         neg_ff    <= neg_in;
         pend_ff   <= pend_in;
         err_ff    <= err_in;
      end
   end

   // character latch and operator decode
   always_ff @(posedge clock) begin
      if (cmd.load_char) begin
         ch_ff <= char_code;
         unique case (char_code)
            CH_PLUS:  op_ff <= OP_ADD;
            CH_MINUS: op_ff <= OP_SUB;
            CH_STAR:  op_ff <= OP_MUL;
            CH_SLASH: op_ff <= OP_DIV;
            default:  op_ff <= OP_POW;
         endcase
      end
   end

   // operand stack, two registered reads for fetch
   always_ff @(posedge clock) begin
      if (push_en && !full) stack_mem[count_ff[SP_WIDTH-1:0]] <= push_val;
      if (cmd.fetch) begin
         opb_ff <= stack_mem[SP_WIDTH'(count_ff - 1'b1)];
         opa_ff <= stack_mem[SP_WIDTH'(count_ff - count_type'(2))];
      end
   end

   // top of stack, registered read kept valid whenever idle
   value_type top_ff;
   always_ff @(posedge clock) begin
      top_ff <= stack_mem[SP_WIDTH'(count_ff - 1'b1)];
   end

   assign top_value = (count_ff == '0) ? '0 : top_ff;
   assign status    = err_ff;

   assign stat.is_digit      = (ch_ff >= CH_ZERO) && (ch_ff <= CH_NINE);
   assign stat.is_minus      = (ch_ff == CH_MINUS);
   assign stat.is_op         = (ch_ff == CH_PLUS) || (ch_ff == CH_STAR)
                               || (ch_ff == CH_SLASH) || (ch_ff == CH_CARET);
   assign stat.in_number     = in_num_ff;
   assign stat.pending_minus = pend_ff;
   assign stat.two_operands  = (count_ff >= count_type'(2));
   assign stat.stack_empty   = (count_ff == '0);
   assign stat.alu_done      = alu_done;
endmodule

### src/pee_controller.sv
// controller: sequences each character through the datapath
// depends on pee_pkg
module pee_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_last,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  pee_pkg::stat_type stat,
   output pee_pkg::cmd_type  cmd
);
   import pee_pkg::*;

   typedef enum logic [3:0] {
      C_IDLE, C_DECODE, C_FIN, C_MINUS, C_MINUS_W, C_MINUS_P, C_OP, C_OP_W, C_OP_P,
      C_END_FIN, C_END_MINUS, C_END_TOP, C_END_TOP2, C_RESP
   } state_type;

   state_type state_ff;
   logic      last_ff, minus_end_ff, rsp_valid_ff;

   // command decode per state
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         C_IDLE:    cmd.load_char = req_valid;
         C_DECODE:  cmd.digit = stat.is_digit;
         C_FIN:     cmd.finish_num = stat.in_number;
         C_MINUS: begin
            cmd.op_minus = 1'b1;
            if (stat.two_operands) cmd.fetch = 1'b1;
            else cmd.set_few = 1'b1;
         end
         C_END_MINUS: begin
            // a held minus at the end is applied as subtraction
            if (stat.pending_minus) begin
               cmd.op_minus = 1'b1;
               if (stat.two_operands) cmd.fetch = 1'b1;
               else cmd.set_few = 1'b1;
            end
         end
         C_MINUS_W: begin cmd.op_minus = 1'b1; cmd.alu_start = 1'b1; end
         C_MINUS_P: cmd.alu_push = stat.alu_done;
         C_OP: begin
            // operators pop two operands, a minus is only held
            if (stat.is_op) begin
               if (stat.two_operands) cmd.fetch = 1'b1;
               else cmd.set_few = 1'b1;
            end
            cmd.set_pending = stat.is_minus;
         end
         C_OP_W:    cmd.alu_start = 1'b1;
         C_OP_P:    cmd.alu_push = stat.alu_done;
         C_END_FIN: cmd.finish_num = stat.in_number;
         C_END_TOP: cmd.set_empty = stat.stack_empty;
         C_RESP:    cmd.clear_all = rsp_ready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= C_IDLE;
         last_ff      <= 1'b0;
         minus_end_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            C_IDLE: if (req_valid) begin
               last_ff  <= req_last;
               state_ff <= C_DECODE;
            end
            C_DECODE: state_ff <= stat.is_digit ? (last_ff ? C_END_FIN : C_IDLE) : C_FIN;
            C_FIN: begin
               minus_end_ff <= 1'b0;
               state_ff <= stat.pending_minus ? C_MINUS : C_OP;
            end
            C_MINUS: state_ff <= stat.two_operands ? C_MINUS_W : C_OP;
            C_MINUS_W: state_ff <= C_MINUS_P;
            C_MINUS_P: if (stat.alu_done)
               state_ff <= minus_end_ff ? C_END_TOP : C_OP;
            C_OP: begin
               // the character itself; a minus only sets pending
               if (stat.is_op && stat.two_operands) state_ff <= C_OP_W;
               else state_ff <= last_ff ? C_END_FIN : C_IDLE;
            end
            C_OP_W: state_ff <= C_OP_P;
            C_OP_P: if (stat.alu_done) state_ff <= last_ff ? C_END_FIN : C_IDLE;
            C_END_FIN: state_ff <= C_END_MINUS;
            C_END_MINUS: begin
               minus_end_ff <= 1'b1;
               if (!stat.pending_minus) state_ff <= C_END_TOP;
               else if (stat.two_operands) state_ff <= C_MINUS_W;
               else state_ff <= C_END_TOP;
            end
            C_END_TOP: state_ff <= C_END_TOP2;
            C_END_TOP2: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= C_RESP;
            end
            C_RESP: if (rsp_ready) begin
               rsp_valid_ff <= 1'b0;
               state_ff     <= C_IDLE;
            end
            default: state_ff <= C_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == C_IDLE);
   assign rsp_valid = rsp_valid_ff;
endmodule

### src/postfix_expression_evaluator.sv
// Postfix integer expression evaluator: one ASCII character per request beat,
// one response beat with the stack top and status on the beat marked last.
// A held minus is resolved as a subtraction before the next non-digit character
// is applied, or at the end. Division takes one restoring step per cycle over
// 32 bits, and power runs one multiply and one square step per exponent bit.
// A new character is taken only when the previous one is done, and the
// response is offered after the last beat has been processed.
// depends on pee_pkg, pee_req_if, pee_rsp_if, pee_controller, pee_datapath
module postfix_expression_evaluator (
   input  logic clock,
   input  logic reset,
   pee_req_if.sink   req,
   pee_rsp_if.source rsp
);
   import pee_pkg::*;

   cmd_type   cmd;
   stat_type  stat;
   value_type top_value;
   logic [2:0] status;

   pee_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_last  (req.last_char),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pee_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .char_code (req.char_code),
      .stat      (stat),
      .top_value (top_value),
      .status    (status)
   );

   // response payload held stable while the beat waits
   assign rsp.value  = top_value;
   assign rsp.status = status;
endmodule

### src/postfix_expression_evaluator_checker.sv
// port-level checker for the postfix expression evaluator, bound to the top
// depends on postfix_expression_evaluator_assert.svh
`include "postfix_expression_evaluator_assert.svh"
module postfix_expression_evaluator_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status
);
   `PEE_ASSERT_IMPL(a_no_req_during_rsp, clock, reset, rsp_valid, !req_ready, "req ready during response")
   `PEE_ASSERT_IMPL(a_status_range, clock, reset, rsp_valid, rsp_status <= 3'd5, "bad status code")
   `PEE_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready, "ready right after accept")
   `PEE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status), "response dropped")
endmodule

bind postfix_expression_evaluator postfix_expression_evaluator_checker u_chk (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req.valid),
   .req_ready  (req.ready),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .rsp_status (rsp.status)
);

### tb/postfix_expression_evaluator_test.sv
// self-checking testbench of the postfix expression evaluator: character beats in,
// stack top and status beats out, compared against a behavioral evaluator
// depends on pee_pkg, pee_req_if, pee_rsp_if, postfix_expression_evaluator
`timescale 1ns / 1ps
module postfix_expression_evaluator_test;
   import pee_pkg::*;

   typedef struct packed {
      value_type  value;
      logic [2:0] status;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pee_req_if req ();
   pee_rsp_if rsp ();

   postfix_expression_evaluator u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   always #4 clock = ~clock;

   // evaluator state
   value_type  eval_stack [STACK_DEPTH];
   int         eval_count;
   value_type  eval_acc;
   logic       eval_in_num;
   logic       eval_neg;
   logic       eval_pend;
   status_type eval_err;

   answer_type answer_queue [$];
   int         error_count;
   int         answer_count;
   int         char_count;

   task automatic clear_evaluator();
      eval_count  = 0;
      eval_acc    = '0;
      eval_in_num = 1'b0;
      eval_neg    = 1'b0;
      eval_pend   = 1'b0;
      eval_err    = ST_OK;
   endtask

   function automatic void note_err(status_type e);
      if (eval_err == ST_OK) eval_err = e;
   endfunction

   function automatic void push_value(value_type v);
      if (eval_count >= STACK_DEPTH) begin
         note_err(ST_OVERFLOW);
      end else begin
         eval_stack[eval_count] = v;
         eval_count++;
      end
   endfunction

   function automatic value_type raise_power(value_type base, value_type ex);
      value_type r;
      value_type b;
      r = 1;
      b = base;
      if (ex[VALUE_WIDTH-1]) begin
         if (b == 1) return 1;
         if (b == '1) return ex[0] ? '1 : 1;
         if (b == 0) note_err(ST_ZERO_POW);
         return 0;
      end
      while (ex != 0) begin
         if (ex[0]) r = r * b;
         b = b * b;
         ex = ex >> 1;
      end
      return r;
   endfunction

   function automatic value_type divide_trunc(value_type a, value_type b);
      value_type ma;
      value_type mb;
      value_type q;
      if (b == 0) begin
         note_err(ST_DIV_ZERO);
         return 0;
      end
      ma = a[VALUE_WIDTH-1] ? -a : a;
      mb = b[VALUE_WIDTH-1] ? -b : b;
      q = ma / mb;
      return (a[VALUE_WIDTH-1] != b[VALUE_WIDTH-1]) ? -q : q;
   endfunction

   function automatic void apply_operator(char_type c);
      value_type a;
      value_type b;
      value_type r;
      if (eval_count < 2) begin
         note_err(ST_FEW);
         return;
      end
      b = eval_stack[eval_count-1];
      a = eval_stack[eval_count-2];
      eval_count -= 2;
      case (c)
         CH_PLUS:  r = a + b;
         CH_MINUS: r = a - b;
         CH_STAR:  r = a * b;
         CH_SLASH: r = divide_trunc(a, b);
         default:  r = raise_power(a, b);
      endcase
      push_value(r);
   endfunction

   function automatic void close_number();
      if (!eval_in_num) return;
      push_value(eval_neg ? -eval_acc : eval_acc);
      eval_in_num = 1'b0;
      eval_neg    = 1'b0;
      eval_acc    = '0;
   endfunction

   function automatic void settle_minus();
      if (eval_pend) begin
         eval_pend = 1'b0;
         apply_operator(CH_MINUS);
      end
   endfunction

   // advance the evaluator by one character, queue the answer on the last one
   task automatic evaluate_char(char_type c, logic last);
      answer_type ans;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         if (eval_in_num) begin
            eval_acc = eval_acc * 10 + value_type'(c - CH_ZERO);
         end else begin
            eval_in_num = 1'b1;
            eval_neg    = eval_pend;
            eval_pend   = 1'b0;
            eval_acc    = value_type'(c - CH_ZERO);
         end
      end else begin
         close_number();
         settle_minus();
         if (c == CH_MINUS) eval_pend = 1'b1;
         else if (c == CH_PLUS || c == CH_STAR || c == CH_SLASH || c == CH_CARET)
            apply_operator(c);
      end
      if (last) begin
         close_number();
         settle_minus();
         if (eval_count == 0) begin
            note_err(ST_EMPTY);
            ans.value = '0;
         end else begin
            ans.value = eval_stack[eval_count-1];
         end
         ans.status = eval_err;
         answer_queue.push_back(ans);
         clear_evaluator();
      end
   endtask

   function automatic int gap_length();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // send one character beat, valid stays up until the next gap or drain
   task automatic send_char(char_type c, logic last);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid     <= 1'b1;
      req.char_code <= c;
      req.last_char <= last;
      evaluate_char(c, last);
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      char_count++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++)
         send_char(char_type'(s[i]), i == s.len() - 1);
   endtask

   task automatic send_number(value_type v, logic neg);
      string s;
      s = $sformatf("%0d", v);
      if (neg) send_char(CH_MINUS, 1'b0);
      for (int i = 0; i < s.len(); i++) send_char(char_type'(s[i]), 1'b0);
   endtask

   task automatic wait_drained();
      req.valid <= 1'b0;
      @(posedge clock);
      while (answer_queue.size() != 0) @(posedge clock);
   endtask

   // response side: random stalls, compare against oldest answer
   initial begin
      answer_type exp_ans;
      int         stall;
      rsp.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = gap_length();
         if (stall > 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         @(posedge clock);
         while (!rsp.valid) @(posedge clock);
         if (answer_queue.size() == 0) begin
            $display("%0t unexpected result beat value %h status %0d", $time,
                     rsp.value, rsp.status);
            error_count++;
         end else begin
            exp_ans = answer_queue.pop_front();
            if (rsp.value !== exp_ans.value)
               begin
                  $display("%0t value mismatch expected %h actual %h", $time,
                           exp_ans.value, rsp.value);
                  error_count++;
               end
            if (rsp.status !== exp_ans.status) begin
               $display("%0t status mismatch expected %0d actual %0d", $time,
                        exp_ans.status, rsp.status);
               error_count++;
            end
         end
         answer_count++;
      end
   end

   // each operator and its corner cases
   task automatic test_operators();
      send_text("3 4+");
      send_text("10 3-");
      send_text("-7 6*");
      send_text("-7 2/");
      send_text("7 -2/");
      send_text("2 10^");
      send_text("2147483647 1+");
      send_text("-2147483648 -1/");
      send_text("4294967301");
      send_text("0 0^");
   endtask

   // error statuses and minus lookahead
   task automatic test_errors();
      send_text("5 0/");
      send_text("+");
      send_text("0 -1^");
      send_text("1 -5^");
      send_text("-1 -3^");
      send_text("-1 -4^");
      send_text("7 -3^");
      send_text(" ");
      send_text("1 2 3");
      send_text("9 4 -");
      send_text("9 4-");
      send_text("1 0/ +");
      send_char(8'hff, 1'b0);
      send_char(8'h00, 1'b1);
      send_text("1 2 3 4 5 6 7 8 9 10 11 12 13 14 15 16 17");
   endtask

   // random well-formed expressions mixed with noise
   task automatic test_random();
      int depth;
      int p;
      char_type c;
      bit drained_once;
      drained_once = 1'b0;
      while (char_count < 830) begin
         if ($urandom_range(0, 9) < 8) begin
            depth = 0;
            repeat ($urandom_range(1, 8)) begin
               p = $urandom_range(0, 9);
               if (depth < 2 || p < 4) begin
                  if ($urandom_range(0, 3) == 0)
                     send_number($urandom, $urandom_range(0, 1));
                  else
                     send_number($urandom_range(0, 20), $urandom_range(0, 1));
                  send_char(8'h20, 1'b0);
                  depth++;
               end else begin
                  case ($urandom_range(0, 4))
                     0: c = CH_PLUS;
                     1: c = CH_MINUS;
                     2: c = CH_STAR;
                     3: c = CH_SLASH;
                     default: c = CH_CARET;
                  endcase
                  send_char(c, 1'b0);
                  depth--;
               end
            end
            send_char(CH_PLUS, 1'b1);
         end else begin
            repeat ($urandom_range(1, 6)) send_char(char_type'($urandom), 1'b0);
            send_char(char_type'($urandom), 1'b1);
         end
         // pause once mid-run until every result is back
         if (!drained_once && char_count > 400) begin
            drained_once = 1'b1;
            wait_drained();
         end
      end
   endtask

   initial begin
      req.valid     <= 1'b0;
      req.char_code <= '0;
      req.last_char <= 1'b0;
      error_count  = 0;
      answer_count = 0;
      char_count   = 0;
      clear_evaluator();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_operators();
      test_errors();
      wait_drained();
      test_random();
      wait_drained();
      repeat (100) @(posedge clock);
      $display("covered %0d character beats and %0d result beats", char_count,
               answer_count);
      $display("operators, sign lookahead, every status code and noise characters");
      if (error_count == 0 && answer_queue.size() == 0)
         $display("postfix_expression_evaluator verification clean");
      else
         $display("postfix_expression_evaluator verification failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("postfix_expression_evaluator verification failed");
      $finish;
   end
endmodule

### filelist.f
+incdir+src
src/pee_pkg.sv
src/pee_if.sv
src/pee_rsp_if.sv
src/pee_alu.sv
src/pee_datapath.sv
src/pee_controller.sv
src/postfix_expression_evaluator.sv
src/postfix_expression_evaluator_checker.sv
tb/postfix_expression_evaluator_test.sv
